// ===== rtl/wrp_pkg.sv =====
// Shared types, chunk signatures and result codes for the WAV RIFF stream parser.
package wrp_pkg;

    localparam logic [31:0] SIG_RIFF = 32'h4646_4952;
    localparam logic [31:0] SIG_WAVE = 32'h4556_4157;
    localparam logic [31:0] SIG_FMT  = 32'h2074_6d66;
    localparam logic [31:0] SIG_DATA = 32'h6174_6164;

    localparam logic [32:0] OFFSET_RESET = 33'd4;
    localparam logic [32:0] OFFSET_MAX   = '1;

    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_REPORT = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_RIFF     = 3'd0;
    localparam logic [2:0] ERR_WAVE     = 3'd1;
    localparam logic [2:0] ERR_TAG      = 3'd2;
    localparam logic [2:0] ERR_FMT_LEN  = 3'd3;
    localparam logic [2:0] ERR_BITS     = 3'd4;

    localparam logic [1:0] FMT_S8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_F32 = 2'd2;

    typedef enum logic [3:0] {
        PH_RIFF,
        PH_SIZE,
        PH_WAVE,
        PH_TAG,
        PH_LEN,
        PH_FMT,
        PH_DATA,
        PH_SKIP,
        PH_DONE,
        PH_ERR
    } t_phase;

    typedef enum logic [1:0] {
        CK_OTHER,
        CK_FMT,
        CK_DATA
    } t_chunk;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       file_start;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sample_byte;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [1:0]  sample_format;
        logic [2:0]  error_code;
        logic        file_done;
    } t_out;

endpackage

// ===== rtl/wrp_parse_core.sv =====
// Parse state registers and the per-byte next-state and result logic.
module wrp_parse_core import wrp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_data,
    output logic o_res_valid,
    output t_out o_res
);

    t_phase      r_phase, n_phase, b_phase;
    logic [3:0]  r_fbc, n_fbc, b_fbc, fbc_inc;
    logic [31:0] r_gather, n_gather, b_gather, gather_sh;
    logic [31:0] r_rem, n_rem, b_rem;
    logic [31:0] r_size, n_size, b_size;
    logic [32:0] r_off, n_off, b_off, len_off;
    logic [33:0] len_sum;
    t_chunk      r_ck, n_ck, b_ck;
    logic [15:0] r_chan, n_chan, b_chan;
    logic [31:0] r_rate, n_rate, b_rate;
    logic        r_err, n_err, b_err;
    logic [1:0]  r_fmt, n_fmt, b_fmt;
    logic        over_cur, over_len;
    logic        res_valid, res_done;
    logic [1:0]  res_kind;
    logic [2:0]  res_code;

    always_comb begin
        if (i_data.file_start) begin
            b_phase  = PH_RIFF;
            b_fbc    = '0;
            b_gather = '0;
            b_rem    = '0;
            b_size   = '0;
            b_off    = OFFSET_RESET;
            b_ck     = CK_OTHER;
            b_chan   = '0;
            b_rate   = '0;
            b_err    = 1'b0;
            b_fmt    = FMT_S8;
        end else begin
            b_phase  = r_phase;
            b_fbc    = r_fbc;
            b_gather = r_gather;
            b_rem    = r_rem;
            b_size   = r_size;
            b_off    = r_off;
            b_ck     = r_ck;
            b_chan   = r_chan;
            b_rate   = r_rate;
            b_err    = r_err;
            b_fmt    = r_fmt;
        end
    end

    assign gather_sh = {i_data.file_byte, b_gather[31:8]};
    assign fbc_inc   = b_fbc + 4'd1;
    assign len_sum   = {1'b0, b_off} + 34'd8 + {2'b00, gather_sh};
    assign len_off   = len_sum[33] ? OFFSET_MAX : len_sum[32:0];
    assign over_cur  = (b_off >= {1'b0, b_size});
    assign over_len  = (len_off >= {1'b0, b_size});

    always_comb begin
        n_phase   = b_phase;
        n_fbc     = b_fbc;
        n_gather  = b_gather;
        n_rem     = b_rem;
        n_size    = b_size;
        n_off     = b_off;
        n_ck      = b_ck;
        n_chan    = b_chan;
        n_rate    = b_rate;
        n_err     = b_err;
        n_fmt     = b_fmt;
        res_valid = 1'b0;
        res_kind  = KIND_REPORT;
        res_code  = ERR_RIFF;
        res_done  = 1'b0;
        if (!b_err && b_phase != PH_DONE && b_phase != PH_ERR) begin
            n_gather = gather_sh;
            n_fbc    = fbc_inc;
            case (b_phase)
                PH_RIFF: begin
                    if (fbc_inc == 4'd4) begin
                        if (gather_sh != SIG_RIFF) begin
                            n_err     = 1'b1;
                            n_phase   = PH_ERR;
                            res_valid = 1'b1;
                            res_kind  = KIND_ERROR;
                            res_code  = ERR_RIFF;
                        end else begin
                            n_phase = PH_SIZE;
                            n_fbc   = '0;
                        end
                    end
                end
                PH_SIZE: begin
                    if (fbc_inc == 4'd4) begin
                        n_size  = gather_sh;
                        n_phase = PH_WAVE;
                        n_fbc   = '0;
                    end
                end
                PH_WAVE: begin
                    if (fbc_inc == 4'd4) begin
                        if (gather_sh != SIG_WAVE) begin
                            n_err     = 1'b1;
                            n_phase   = PH_ERR;
                            res_valid = 1'b1;
                            res_kind  = KIND_ERROR;
                            res_code  = ERR_WAVE;
                        end else begin
                            n_off = OFFSET_RESET;
                            if (b_size <= 32'd4) begin
                                n_phase   = PH_DONE;
                                res_valid = 1'b1;
                                res_kind  = KIND_REPORT;
                                res_done  = 1'b1;
                            end else begin
                                n_phase = PH_TAG;
                                n_fbc   = '0;
                            end
                        end
                    end
                end
                PH_TAG: begin
                    if (fbc_inc == 4'd4) begin
                        if (gather_sh == SIG_FMT) begin
                            n_ck = CK_FMT;
                        end else if (gather_sh == SIG_DATA) begin
                            n_ck = CK_DATA;
                        end else begin
                            n_ck = CK_OTHER;
                        end
                        n_phase = PH_LEN;
                        n_fbc   = '0;
                    end
                end
                PH_LEN: begin
                    if (fbc_inc == 4'd4) begin
                        n_rem = gather_sh;
                        n_off = len_off;
                        n_fbc = '0;
                        if (b_ck == CK_FMT) begin
                            n_phase = PH_FMT;
                        end else if (gather_sh != '0) begin
                            n_phase = (b_ck == CK_DATA) ? PH_DATA : PH_SKIP;
                        end else if (over_len) begin
                            n_phase   = PH_DONE;
                            res_valid = 1'b1;
                            res_kind  = KIND_REPORT;
                            res_done  = 1'b1;
                        end else begin
                            n_phase = PH_TAG;
                        end
                    end
                end
                PH_FMT: begin
                    if (fbc_inc == 4'd2) begin
                        if (gather_sh[31:16] != 16'd1) begin
                            n_err     = 1'b1;
                            n_phase   = PH_ERR;
                            res_valid = 1'b1;
                            res_kind  = KIND_ERROR;
                            res_code  = ERR_TAG;
                        end else if (b_rem != 32'd16) begin
                            n_err     = 1'b1;
                            n_phase   = PH_ERR;
                            res_valid = 1'b1;
                            res_kind  = KIND_ERROR;
                            res_code  = ERR_FMT_LEN;
                        end
                    end else if (fbc_inc == 4'd4) begin
                        n_chan = gather_sh[31:16];
                    end else if (fbc_inc == 4'd8) begin
                        n_rate = gather_sh;
                    end else if (fbc_inc == 4'd0) begin
                        res_valid = 1'b1;
                        if (gather_sh[31:16] == 16'd8 || gather_sh[31:16] == 16'd16 ||
                            gather_sh[31:16] == 16'd32) begin
                            if (gather_sh[31:16] == 16'd8) begin
                                n_fmt = FMT_S8;
                            end else if (gather_sh[31:16] == 16'd16) begin
                                n_fmt = FMT_S16;
                            end else begin
                                n_fmt = FMT_F32;
                            end
                            res_kind = KIND_REPORT;
                            res_done = over_cur;
                            n_phase  = over_cur ? PH_DONE : PH_TAG;
                        end else begin
                            n_err    = 1'b1;
                            n_phase  = PH_ERR;
                            res_kind = KIND_ERROR;
                            res_code = ERR_BITS;
                        end
                    end
                end
                PH_DATA: begin
                    n_rem     = b_rem - 32'd1;
                    res_valid = 1'b1;
                    res_kind  = KIND_DATA;
                    if (b_rem == 32'd1) begin
                        res_done = over_cur;
                        n_phase  = over_cur ? PH_DONE : PH_TAG;
                        n_fbc    = '0;
                    end
                end
                PH_SKIP: begin
                    n_rem = b_rem - 32'd1;
                    if (b_rem == 32'd1) begin
                        n_fbc = '0;
                        if (over_cur) begin
                            n_phase   = PH_DONE;
                            res_valid = 1'b1;
                            res_kind  = KIND_REPORT;
                            res_done  = 1'b1;
                        end else begin
                            n_phase = PH_TAG;
                        end
                    end
                end
                default: begin
                    n_gather = b_gather;
                    n_fbc    = b_fbc;
                end
            endcase
        end
    end

    always_comb begin
        o_res_valid         = res_valid;
        o_res.kind          = res_kind;
        o_res.sample_byte   = (res_kind == KIND_DATA) ? i_data.file_byte : 8'd0;
        o_res.channels      = (res_kind == KIND_REPORT) ? n_chan : 16'd0;
        o_res.sample_rate   = (res_kind == KIND_REPORT) ? n_rate : 32'd0;
        o_res.sample_format = (res_kind == KIND_REPORT) ? n_fmt : FMT_S8;
        o_res.error_code    = (res_kind == KIND_ERROR) ? res_code : ERR_RIFF;
        o_res.file_done     = res_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_RIFF;
            r_fbc    <= '0;
            r_gather <= '0;
            r_rem    <= '0;
            r_size   <= '0;
            r_off    <= OFFSET_RESET;
            r_ck     <= CK_OTHER;
            r_chan   <= '0;
            r_rate   <= '0;
            r_err    <= 1'b0;
            r_fmt    <= FMT_S8;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_fbc    <= n_fbc;
            r_gather <= n_gather;
            r_rem    <= n_rem;
            r_size   <= n_size;
            r_off    <= n_off;
            r_ck     <= n_ck;
            r_chan   <= n_chan;
            r_rate   <= n_rate;
            r_err    <= n_err;
            r_fmt    <= n_fmt;
        end
    end

`ifndef ASSERT_OFF
    a_err_phase : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err == (r_phase == PH_ERR))
        else $error("error flag and error phase disagree");

    a_err_not_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && res_kind == KIND_ERROR) |-> !res_done)
        else $error("error result flagged as file end");

    a_riff_offset : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RIFF) |-> (r_off == OFFSET_RESET))
        else $error("offset not at start value while expecting signature");
`endif

endmodule

// ===== rtl/wrp_out_buf.sv =====
// Output register with a skid stage for result transactions.
module wrp_out_buf import wrp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_out i_res,
    output logic o_full,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    logic r_out_valid, r_skid_valid;
    t_out r_out, r_skid;
    logic take;

    assign take    = r_out_valid && !i_stall;
    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (i_push) begin
            if (!r_out_valid || take) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end

`ifndef ASSERT_OFF
    a_skid_needs_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a transaction while output is empty");

    a_skid_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_stall) |=> (r_skid_valid && $stable(r_skid)))
        else $error("skid transaction lost under stall");

    a_skid_fill : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall && i_push))
        else $error("skid stage filled without a stalled output");
`endif

endmodule

// ===== rtl/wav_riff_stream_parser.sv =====
// Top level of the WAV RIFF stream parser: byte input channel, result output channel.
// Takes one WAV file byte per transaction and can accept a byte every cycle; each byte is
// parsed in the cycle it is accepted and its result, if any, is registered in the output
// or skid stage. A two-deep output register (output stage plus skid stage) decouples the
// sides, so input is stalled only when both stages hold undelivered results. Results are
// data chunk bytes, one format report per fmt chunk (or at file end when the end falls on
// a byte that yields nothing else), and a single error per file; after an error or the
// end of the RIFF walk, bytes are consumed silently until file_start marks a new file.
// The first file after reset needs no file_start.
module wav_riff_stream_parser import wrp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic accept;
    logic res_valid;
    t_out res;
    logic buf_full;

    assign o_stall = buf_full;
    assign accept  = i_valid && !buf_full;

    wrp_parse_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data      (i_data),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wrp_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && res_valid),
        .i_res   (res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule
